// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the gripper sequencer.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define SGS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SGS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/sgs_pkg.sv -----
// Package of the suction gripper sequencer: step, action and command codes,
// register indexes, reset values and the structs passed between modules. No dependencies.
package sgs_pkg;

    localparam int unsigned TimerW = 16;

    // Sequence steps.
    localparam logic [3:0] ST_IDLE        = 4'd0;
    localparam logic [3:0] ST_LOWER_PICK  = 4'd1;
    localparam logic [3:0] ST_PUMP        = 4'd2;
    localparam logic [3:0] ST_LIFT        = 4'd3;
    localparam logic [3:0] ST_HOLDING     = 4'd4;
    localparam logic [3:0] ST_LOWER_DROP  = 4'd5;
    localparam logic [3:0] ST_VALVE_OPEN  = 4'd6;
    localparam logic [3:0] ST_PUMP_STOP   = 4'd7;
    localparam logic [3:0] ST_VALVE_CLOSE = 4'd8;
    localparam logic [3:0] ST_RETURN      = 4'd9;

    // Actuator actions.
    localparam logic [2:0] ACT_NONE        = 3'd0;
    localparam logic [2:0] ACT_SERVO       = 3'd1;
    localparam logic [2:0] ACT_PUMP_ON     = 3'd2;
    localparam logic [2:0] ACT_PUMP_OFF    = 3'd3;
    localparam logic [2:0] ACT_VALVE_OPEN  = 3'd4;
    localparam logic [2:0] ACT_VALVE_CLOSE = 3'd5;

    // Servo targets.
    localparam logic [1:0] SRV_SUCTION = 2'd0;
    localparam logic [1:0] SRV_HOLD    = 2'd1;
    localparam logic [1:0] SRV_RELEASE = 2'd2;
    localparam logic [1:0] SRV_IDLE    = 2'd3;

    // Commands and input kinds.
    localparam logic [1:0] CMD_IDLE    = 2'd0;
    localparam logic [1:0] CMD_SUCTION = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic       KIND_TICK   = 1'b0;
    localparam logic       KIND_CMD    = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_MOVE_DELAY    = 2'd0;
    localparam logic [1:0] REG_PUMP_DELAY    = 2'd1;
    localparam logic [1:0] REG_RELEASE_DELAY = 2'd2;

    localparam logic [TimerW-1:0] TICK_MS          = 16'd10;
    localparam logic [TimerW-1:0] SETTLE_MS        = 16'd100;
    localparam logic [TimerW-1:0] MOVE_DELAY_RST   = 16'd500;
    localparam logic [TimerW-1:0] PUMP_DELAY_RST   = 16'd1000;
    localparam logic [TimerW-1:0] RELEASE_DELAY_RST = 16'd500;

    typedef struct packed {
        logic [TimerW-1:0] move_ms;
        logic [TimerW-1:0] pump_ms;
        logic [TimerW-1:0] release_ms;
    } t_delay_cfg;

    typedef struct packed {
        logic [3:0]        step;
        logic [TimerW-1:0] elapsed;
        logic [1:0]        cmd;
    } t_seq_state;

    typedef struct packed {
        logic [1:0] target;
        logic [2:0] action;
        logic [1:0] pending;
        logic       busy;
        logic [3:0] step;
    } t_result;

endpackage

// ----- rtl/sgs_step_logic.sv -----
// Next-state and result logic of the gripper sequencer for one tick or command.
// Depends on sgs_pkg.
module sgs_step_logic (
    input  sgs_pkg::t_seq_state i_state,
    input  sgs_pkg::t_delay_cfg i_cfg,
    input  logic                i_kind,
    input  logic [1:0]          i_cmd,
    output sgs_pkg::t_seq_state o_state,
    output sgs_pkg::t_result    o_res
);
    import sgs_pkg::*;

    logic [TimerW:0]   tick_sum;
    logic [TimerW-1:0] timer;
    logic [2:0]        act;
    logic [1:0]        tgt;
    t_seq_state        nxt;

    // Saturating timer advance.
    assign tick_sum = {1'b0, i_state.elapsed} + {1'b0, TICK_MS};
    assign timer    = tick_sum[TimerW] ? {TimerW{1'b1}} : tick_sum[TimerW-1:0];

    always_comb begin
        nxt = i_state;
        act = ACT_NONE;
        tgt = SRV_SUCTION;
        if (i_kind == KIND_CMD) begin
            // Code 3 is not a command and leaves the latch alone.
            if (i_cmd inside {CMD_IDLE, CMD_SUCTION, CMD_RELEASE}) begin
                nxt.cmd = i_cmd;
            end
        end else begin
            nxt.elapsed = timer;
            case (i_state.step)
                ST_IDLE: begin
                    if (i_state.cmd == CMD_SUCTION) begin
                        act = ACT_SERVO;
                        tgt = SRV_SUCTION;
                        nxt.step = ST_LOWER_PICK;
                        nxt.elapsed = '0;
                    end
                end
                ST_LOWER_PICK: begin
                    if (timer >= i_cfg.move_ms) begin
                        act = ACT_PUMP_ON;
                        nxt.step = ST_PUMP;
                        nxt.elapsed = '0;
                    end
                end
                ST_PUMP: begin
                    if (timer >= i_cfg.pump_ms) begin
                        act = ACT_SERVO;
                        tgt = SRV_HOLD;
                        nxt.step = ST_LIFT;
                        nxt.elapsed = '0;
                    end
                end
                ST_LIFT: begin
                    if (timer >= i_cfg.move_ms) begin
                        nxt.step = ST_HOLDING;
                        nxt.cmd = CMD_IDLE;
                    end
                end
                ST_HOLDING: begin
                    if (i_state.cmd == CMD_RELEASE) begin
                        act = ACT_SERVO;
                        tgt = SRV_RELEASE;
                        nxt.step = ST_LOWER_DROP;
                        nxt.elapsed = '0;
                    end
                end
                ST_LOWER_DROP: begin
                    if (timer >= i_cfg.move_ms) begin
                        act = ACT_VALVE_OPEN;
                        nxt.step = ST_VALVE_OPEN;
                        nxt.elapsed = '0;
                    end
                end
                ST_VALVE_OPEN: begin
                    if (timer >= i_cfg.release_ms) begin
                        act = ACT_PUMP_OFF;
                        nxt.step = ST_PUMP_STOP;
                        nxt.elapsed = '0;
                    end
                end
                ST_PUMP_STOP: begin
                    if (timer >= SETTLE_MS) begin
                        act = ACT_VALVE_CLOSE;
                        nxt.step = ST_VALVE_CLOSE;
                        nxt.elapsed = '0;
                    end
                end
                ST_VALVE_CLOSE: begin
                    if (timer >= SETTLE_MS) begin
                        act = ACT_SERVO;
                        tgt = SRV_IDLE;
                        nxt.step = ST_RETURN;
                        nxt.elapsed = '0;
                    end
                end
                ST_RETURN: begin
                    if (timer >= i_cfg.move_ms) begin
                        nxt.step = ST_IDLE;
                        nxt.cmd = CMD_IDLE;
                    end
                end
                default: begin
                    // Undefined step codes fall back to idle.
                    nxt.step = ST_IDLE;
                end
            endcase
        end
    end

    assign o_state        = nxt;
    assign o_res.step     = nxt.step;
    assign o_res.busy     = (nxt.step != ST_IDLE) && (nxt.step != ST_HOLDING);
    assign o_res.pending  = nxt.cmd;
    assign o_res.action   = act;
    assign o_res.target   = tgt;

endmodule

// ----- rtl/suction_gripper_sequencer_unit.sv -----
// A transaction accepted into the input register is captured by the result register when
// the result stage advances, and its result is then offered downstream.
// Throughput: one transaction per cycle unless the result side stalls; the result register
// and sequencer state are both written by one short pass of step logic between the registers.
// Reset (i_rst_n low, synchronous): step idle, timer zero, no latched command,
// delays back to 500/1000/500 ms and both pipeline registers empty.
// Top level of the suction gripper sequencer; depends on sgs_pkg and sgs_step_logic.
module suction_gripper_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side: tick or command transactions.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [1:0] command, [7:2] zero
    input  logic [0:0]  i_s_tuser,   // [0] kind (0 tick, 1 command)
    // Master side: one result per input transaction.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [3:0] sequence_step, [4] busy_res, [6:5] pending_cmd,
                                     // [9:7] action, [11:10] servo_target, [15:12] zero
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import sgs_pkg::*;

    // Input register.
    logic       r_in_valid;
    logic       r_in_kind;
    logic [1:0] r_in_cmd;

    // Sequencer state and delay registers.
    t_seq_state r_state;
    t_seq_state n_state;
    t_delay_cfg r_cfg;

    // Result register.
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic advance;
    logic in_take;

    // The result stage moves whenever its register is empty or being drained, so a new transaction
    // can enter an empty input register while an older result still waits for the downstream side.
    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;

    // Configuration writes are to be issued only while idle; the block does not enforce this. The port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.move_ms    <= MOVE_DELAY_RST;
            r_cfg.pump_ms    <= PUMP_DELAY_RST;
            r_cfg.release_ms <= RELEASE_DELAY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MOVE_DELAY:    r_cfg.move_ms    <= i_cfg_data;
                REG_PUMP_DELAY:    r_cfg.pump_ms    <= i_cfg_data;
                REG_RELEASE_DELAY: r_cfg.release_ms <= i_cfg_data;
                default: begin
                    // Writes to an unused index are dropped.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_kind <= i_s_tuser[0];
            r_in_cmd  <= i_s_tdata[1:0];
        end
    end

    sgs_step_logic u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_kind  (r_in_kind),
        .i_cmd   (r_in_cmd),
        .o_state (n_state),
        .o_res   (n_out)
    );

    // The state is committed in the same edge the result is captured, so the next
    // transaction in the input register always sees the updated step and timer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.step    <= ST_IDLE;
            r_state.elapsed <= '0;
            r_state.cmd     <= CMD_IDLE;
            r_out_valid     <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out.target, r_out.action, r_out.pending,
                         r_out.busy, r_out.step};

endmodule

// ----- rtl/sgs_checker.sv -----
// Port-level checker for the gripper sequencer and its bind to the top level.
// Depends on sgs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sgs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);
    import sgs_pkg::*;

    logic [3:0] step;
    logic       busy;
    logic [2:0] action;
    logic [1:0] target;

    assign step   = o_m_tdata[3:0];
    assign busy   = o_m_tdata[4];
    assign action = o_m_tdata[9:7];
    assign target = o_m_tdata[11:10];

    // A stalled result stays put.
    `SGS_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "result changed while stalled")
    // Reported steps are always defined ones.
    `SGS_ASSERT(a_step_range, i_clk, i_rst_n, o_m_tvalid |-> step <= ST_RETURN, "undefined step reported")
    // The busy flag follows the step.
    `SGS_ASSERT(a_busy_match, i_clk, i_rst_n, o_m_tvalid |-> busy == (step != ST_IDLE && step != ST_HOLDING), "busy flag disagrees with step")
    // A servo target only comes with a servo move.
    `SGS_ASSERT(a_target_zero, i_clk, i_rst_n, o_m_tvalid && action != ACT_SERVO |-> target == SRV_SUCTION, "servo target without servo move")

endmodule

bind suction_gripper_sequencer_unit sgs_checker u_sgs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
